@@ hw/rtl/cbp_pkg.sv @@
// ----------------------------------------------------------------------------
// cbp_pkg: shared types and constants for the cylinder/box push-out block
// Payload structs, codes, pipeline sizes and the saturation helper.
// ----------------------------------------------------------------------------
package cbp_pkg;

   localparam int FRAC_BITS = 16;
   // squared distance below 1e-8 in Q(2*FRAC_BITS)
   localparam logic [63:0] NEAR_ZERO_SQ =
      ((64'd1 << (2 * FRAC_BITS)) / 64'd100000000) + 64'd1;
   localparam logic [30:0] MIN_Y_RESET = 31'd3277;

   localparam int SQRT_STEPS  = 31;
   localparam int DIV_STEPS   = 32;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   // sqrt stages + multiply + divide stages + output
   localparam int BACK_STAGES = (SQRT_STEPS + 1) + 1 + (DIV_STEPS + 1) + 1;

   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_EDGE   = 2'd1,
      KIND_INSIDE = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      FACE_LEFT  = 2'd0,
      FACE_RIGHT = 2'd1,
      FACE_FRONT = 2'd2,
      FACE_BACK  = 2'd3
   } face_type;

   typedef struct packed {
      logic signed [31:0] cyl_center_x;
      logic signed [31:0] cyl_center_z;
      logic signed [31:0] cyl_bottom_y;
      logic signed [31:0] cyl_top_y;
      logic        [30:0] cyl_radius;
      logic signed [31:0] box_min_x;
      logic signed [31:0] box_min_y;
      logic signed [31:0] box_min_z;
      logic signed [31:0] box_max_x;
      logic signed [31:0] box_max_y;
      logic signed [31:0] box_max_z;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic        [1:0]  hit_kind;
      logic signed [31:0] push_x;
      logic signed [31:0] push_z;
   } rsp_type;

   // classified item handed from the front to the back
   typedef struct packed {
      logic               hit;
      logic               near;
      face_type           face;
      logic signed [31:0] inside_push;
      logic               sx;
      logic               sz;
      logic        [30:0] adx;
      logic        [30:0] adz;
      logic        [30:0] r;
      logic        [61:0] dsq;
   } back_item_type;

   function automatic logic [31:0] sat35(input logic signed [34:0] v);
      logic [31:0] res;
      if (v > 35'sh0_7FFF_FFFF)
         res = 32'h7FFF_FFFF;
      else if (v < -35'sh0_8000_0000)
         res = 32'h8000_0000;
      else
         res = v[31:0];
      return res;
   endfunction

endpackage

@@ hw/rtl/cbp_front.sv @@
// ----------------------------------------------------------------------------
// cbp_front: intake and classification
// Four stages: clamp and offsets, range checks and face pick, squares,
// hit and near-zero decision. Feeds the item queue.
// ----------------------------------------------------------------------------
module cbp_front import cbp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic [30:0]   min_y_overlap,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_type       req_data,
   output logic          item_valid,
   input  logic          item_full,
   output back_item_type item_data
);

   logic f_adv;
   logic [3:0] vld_ff, vld_in;

   // stage 1
   logic signed [32:0] yov_ff, dx_ff, dz_ff, dl_ff, dr_ff, df_ff, db_ff;
   logic signed [32:0] yov_in, dx_in, dz_in, dl_in, dr_in, df_in, db_in;
   logic        [30:0] r1_ff;
   logic signed [31:0] top_lo, bot_hi, tx, tz, nx, nz;

   // stage 2
   logic               ok2_ff, ok2_in, sx2_ff, sz2_ff;
   logic        [30:0] adx2_ff, adz2_ff, adx2_in, adz2_in, r2_ff;
   logic signed [32:0] least2_ff, least2_in;
   face_type           face2_ff, face2_in;
   logic        [32:0] adx_full, adz_full;
   logic               yok, xok, zok;

   // stage 3
   logic        [61:0] sqx3_ff, sqz3_ff, rsq3_ff, sqx3_in, sqz3_in, rsq3_in;
   logic               ok3_ff, sx3_ff, sz3_ff;
   logic        [30:0] adx3_ff, adz3_ff, r3_ff;
   face_type           face3_ff;
   logic signed [31:0] pin3_ff, pin3_in;
   logic signed [33:0] depth_in;
   logic signed [34:0] praw;

   // stage 4
   back_item_type item_ff, item_in;
   logic [62:0] dsq;

   assign f_adv      = !(vld_ff[3] && item_full);
   assign req_stall  = !f_adv;
   assign item_valid = vld_ff[3];
   assign item_data  = item_ff;

   assign vld_in = {vld_ff[2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (f_adv) begin
         vld_ff <= vld_in;
      end
   end

   // clamp the center onto the box, vertical overlap, face distances
   always_comb begin
      top_lo = (req_data.cyl_top_y < req_data.box_max_y) ?
               req_data.cyl_top_y : req_data.box_max_y;
      bot_hi = (req_data.cyl_bottom_y > req_data.box_min_y) ?
               req_data.cyl_bottom_y : req_data.box_min_y;
      tx = (req_data.cyl_center_x < req_data.box_max_x) ?
           req_data.cyl_center_x : req_data.box_max_x;
      nx = (req_data.box_min_x > tx) ? req_data.box_min_x : tx;
      tz = (req_data.cyl_center_z < req_data.box_max_z) ?
           req_data.cyl_center_z : req_data.box_max_z;
      nz = (req_data.box_min_z > tz) ? req_data.box_min_z : tz;
      yov_in = {top_lo[31], top_lo} - {bot_hi[31], bot_hi};
      dx_in  = {req_data.cyl_center_x[31], req_data.cyl_center_x} - {nx[31], nx};
      dz_in  = {req_data.cyl_center_z[31], req_data.cyl_center_z} - {nz[31], nz};
      dl_in  = {req_data.cyl_center_x[31], req_data.cyl_center_x}
             - {req_data.box_min_x[31], req_data.box_min_x};
      dr_in  = {req_data.box_max_x[31], req_data.box_max_x}
             - {req_data.cyl_center_x[31], req_data.cyl_center_x};
      df_in  = {req_data.cyl_center_z[31], req_data.cyl_center_z}
             - {req_data.box_min_z[31], req_data.box_min_z};
      db_in  = {req_data.box_max_z[31], req_data.box_max_z}
             - {req_data.cyl_center_z[31], req_data.cyl_center_z};
   end

   always_ff @(posedge clock) begin
      if (f_adv) begin
         yov_ff <= yov_in;
         dx_ff  <= dx_in;
         dz_ff  <= dz_in;
         dl_ff  <= dl_in;
         dr_ff  <= dr_in;
         df_ff  <= df_in;
         db_ff  <= db_in;
         r1_ff  <= req_data.cyl_radius;
      end
   end

   // range checks and nearest face, strict-less ties
   always_comb begin
      adx_full = dx_ff[32] ? 33'(-dx_ff) : 33'(dx_ff);
      adz_full = dz_ff[32] ? 33'(-dz_ff) : 33'(dz_ff);
      yok = yov_ff >= $signed({2'b00, min_y_overlap});
      xok = adx_full < {2'b00, r1_ff};
      zok = adz_full < {2'b00, r1_ff};
      ok2_in  = yok && xok && zok;
      adx2_in = ok2_in ? adx_full[30:0] : '0;
      adz2_in = ok2_in ? adz_full[30:0] : '0;
      least2_in = dl_ff;
      face2_in  = FACE_LEFT;
      if (dr_ff < least2_in) begin
         least2_in = dr_ff;
         face2_in  = FACE_RIGHT;
      end
      if (df_ff < least2_in) begin
         least2_in = df_ff;
         face2_in  = FACE_FRONT;
      end
      if (db_ff < least2_in) begin
         least2_in = db_ff;
         face2_in  = FACE_BACK;
      end
   end

   always_ff @(posedge clock) begin
      if (f_adv) begin
         ok2_ff    <= ok2_in;
         adx2_ff   <= adx2_in;
         adz2_ff   <= adz2_in;
         sx2_ff    <= dx_ff[32];
         sz2_ff    <= dz_ff[32];
         least2_ff <= least2_in;
         face2_ff  <= face2_in;
         r2_ff     <= r1_ff;
      end
   end

   // squares and the inside push
   always_comb begin
      sqx3_in  = adx2_ff * adx2_ff;
      sqz3_in  = adz2_ff * adz2_ff;
      rsq3_in  = r2_ff * r2_ff;
      depth_in = {least2_ff[32], least2_ff} + {3'b000, r2_ff};
      if (face2_ff == FACE_LEFT || face2_ff == FACE_FRONT)
         praw = -{depth_in[33], depth_in};
      else
         praw = {depth_in[33], depth_in};
      pin3_in = sat35(praw);
   end

   always_ff @(posedge clock) begin
      if (f_adv) begin
         sqx3_ff  <= sqx3_in;
         sqz3_ff  <= sqz3_in;
         rsq3_ff  <= rsq3_in;
         ok3_ff   <= ok2_ff;
         sx3_ff   <= sx2_ff;
         sz3_ff   <= sz2_ff;
         adx3_ff  <= adx2_ff;
         adz3_ff  <= adz2_ff;
         r3_ff    <= r2_ff;
         face3_ff <= face2_ff;
         pin3_ff  <= pin3_in;
      end
   end

   always_comb begin
      dsq = {1'b0, sqx3_ff} + {1'b0, sqz3_ff};
      item_in.hit         = ok3_ff && (dsq < {1'b0, rsq3_ff});
      item_in.near        = dsq < NEAR_ZERO_SQ[62:0];
      item_in.face        = face3_ff;
      item_in.inside_push = pin3_ff;
      item_in.sx          = sx3_ff;
      item_in.sz          = sz3_ff;
      item_in.adx         = adx3_ff;
      item_in.adz         = adz3_ff;
      item_in.r           = r3_ff;
      item_in.dsq         = dsq[61:0];
   end

   always_ff @(posedge clock) begin
      if (f_adv) begin
         item_ff <= item_in;
      end
   end

endmodule

@@ hw/rtl/cbp_queue.sv @@
// ----------------------------------------------------------------------------
// cbp_queue: short item queue between front and back
// Register-based FIFO; lets the front keep accepting while the back stalls.
// ----------------------------------------------------------------------------
module cbp_queue import cbp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          full,
   input  back_item_type push_data,
   input  logic          pop,
   output logic          pop_valid,
   output back_item_type pop_data
);

   back_item_type         mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [QUEUE_AW:0]     cnt_ff, cnt_in;
   logic                  do_push, do_pop;

   assign full      = cnt_ff == (QUEUE_AW + 1)'(QUEUE_DEPTH);
   assign pop_valid = cnt_ff != '0;
   assign pop_data  = mem_ff[rd_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop)
         cnt_in = cnt_ff + 1'b1;
      else if (do_pop && !do_push)
         cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

@@ hw/rtl/cbp_back.sv @@
// ----------------------------------------------------------------------------
// cbp_back: distance, depth and push computation
// Pipelined square root (one result bit per stage), depth multiply,
// pipelined rounding divide for both axes, then sign and saturation.
// ----------------------------------------------------------------------------
module cbp_back import cbp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          item_valid,
   output logic          item_pop,
   input  back_item_type item_data,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_data
);

   logic adv;
   logic [BACK_STAGES-1:0] vld_ff, vld_in;

   back_item_type sq_item_ff [SQRT_STEPS+1];
   logic [61:0]   sq_v_ff    [SQRT_STEPS+1];
   logic [61:0]   sq_root_ff [SQRT_STEPS+1];

   back_item_type mul_item_ff;
   logic [61:0]   mul_px_ff, mul_pz_ff, mul_px_in, mul_pz_in;
   logic [30:0]   mul_dist_ff, mul_dist_in, depth;

   back_item_type dv_item_ff [DIV_STEPS+1];
   logic [62:0]   dv_rx_ff   [DIV_STEPS+1];
   logic [62:0]   dv_rz_ff   [DIV_STEPS+1];
   logic [31:0]   dv_qx_ff   [DIV_STEPS+1];
   logic [31:0]   dv_qz_ff   [DIV_STEPS+1];
   logic [30:0]   dv_dist_ff [DIV_STEPS+1];

   rsp_type       rsp_ff, rsp_in;
   back_item_type fin;
   logic [31:0]   qx, qz;

   assign adv       = !(vld_ff[BACK_STAGES-1] && rsp_stall);
   assign item_pop  = adv && item_valid;
   assign rsp_valid = vld_ff[BACK_STAGES-1];
   assign rsp_data  = rsp_ff;
   assign vld_in    = {vld_ff[BACK_STAGES-2:0], item_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // load from the queue
   always_ff @(posedge clock) begin
      if (adv) begin
         sq_item_ff[0] <= item_data;
         sq_v_ff[0]    <= item_data.dsq;
         sq_root_ff[0] <= '0;
      end
   end

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      localparam logic [61:0] BitVal = 62'd1 << (2 * (SQRT_STEPS - 1 - k));
      logic [61:0] trial, v_in, root_in;
      always_comb begin
         trial = sq_root_ff[k] + BitVal;
         if (sq_v_ff[k] >= trial) begin
            v_in    = sq_v_ff[k] - trial;
            root_in = (sq_root_ff[k] >> 1) + BitVal;
         end else begin
            v_in    = sq_v_ff[k];
            root_in = sq_root_ff[k] >> 1;
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            sq_item_ff[k+1] <= sq_item_ff[k];
            sq_v_ff[k+1]    <= v_in;
            sq_root_ff[k+1] <= root_in;
         end
      end
   end

   // depth times offset
   always_comb begin
      mul_dist_in = sq_root_ff[SQRT_STEPS][30:0];
      depth       = sq_item_ff[SQRT_STEPS].r - mul_dist_in;
      mul_px_in   = sq_item_ff[SQRT_STEPS].adx * depth;
      mul_pz_in   = sq_item_ff[SQRT_STEPS].adz * depth;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mul_item_ff <= sq_item_ff[SQRT_STEPS];
         mul_px_ff   <= mul_px_in;
         mul_pz_ff   <= mul_pz_in;
         mul_dist_ff <= mul_dist_in;
      end
   end

   // add half the divisor for round-to-nearest
   always_ff @(posedge clock) begin
      if (adv) begin
         dv_item_ff[0] <= mul_item_ff;
         dv_rx_ff[0]   <= {1'b0, mul_px_ff} + {33'd0, mul_dist_ff[30:1]};
         dv_rz_ff[0]   <= {1'b0, mul_pz_ff} + {33'd0, mul_dist_ff[30:1]};
         dv_qx_ff[0]   <= '0;
         dv_qz_ff[0]   <= '0;
         dv_dist_ff[0] <= mul_dist_ff;
      end
   end

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      localparam int Shift = DIV_STEPS - 1 - k;
      logic [62:0] sh, rx_in, rz_in;
      logic [31:0] qx_in, qz_in;
      always_comb begin
         sh    = {32'd0, dv_dist_ff[k]} << Shift;
         rx_in = dv_rx_ff[k];
         rz_in = dv_rz_ff[k];
         qx_in = dv_qx_ff[k];
         qz_in = dv_qz_ff[k];
         if (dv_rx_ff[k] >= sh) begin
            rx_in        = dv_rx_ff[k] - sh;
            qx_in[Shift] = 1'b1;
         end
         if (dv_rz_ff[k] >= sh) begin
            rz_in        = dv_rz_ff[k] - sh;
            qz_in[Shift] = 1'b1;
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            dv_item_ff[k+1] <= dv_item_ff[k];
            dv_rx_ff[k+1]   <= rx_in;
            dv_rz_ff[k+1]   <= rz_in;
            dv_qx_ff[k+1]   <= qx_in;
            dv_qz_ff[k+1]   <= qz_in;
            dv_dist_ff[k+1] <= dv_dist_ff[k];
         end
      end
   end

   // apply signs, saturate, pick the result kind
   always_comb begin
      fin = dv_item_ff[DIV_STEPS];
      qx  = dv_qx_ff[DIV_STEPS];
      qz  = dv_qz_ff[DIV_STEPS];
      rsp_in.hit      = 1'b0;
      rsp_in.hit_kind = KIND_NONE;
      rsp_in.push_x   = '0;
      rsp_in.push_z   = '0;
      if (fin.hit && fin.near) begin
         rsp_in.hit      = 1'b1;
         rsp_in.hit_kind = KIND_INSIDE;
         if (fin.face == FACE_LEFT || fin.face == FACE_RIGHT)
            rsp_in.push_x = fin.inside_push;
         else
            rsp_in.push_z = fin.inside_push;
      end else if (fin.hit) begin
         rsp_in.hit      = 1'b1;
         rsp_in.hit_kind = KIND_EDGE;
         rsp_in.push_x   = sat35(fin.sx ? -{3'b000, qx} : {3'b000, qx});
         rsp_in.push_z   = sat35(fin.sz ? -{3'b000, qz} : {3'b000, qz});
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

@@ hw/rtl/cylinder_box_push_out.sv @@
// ----------------------------------------------------------------------------
// cylinder_box_push_out: horizontal push-out of a vertical cylinder from a box
// Top level: configuration register, front classifier, item queue, back end.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item (cylinder plus box, Q16.16) under valid/stall;
//   it is taken on an edge with req_valid high and req_stall low.
//   rsp_* returns exactly one result item per request, in order, held
//   stable while rsp_stall is high.
//   csr_* writes min_y_overlap; csr_ready is always high. Write it only
//   while no items are in flight.
// Throughput: one item per cycle while rsp_stall is low. The back end
//   is a 31-stage square root and a 32-stage divider, fully pipelined,
//   so nothing is iterated.
// Path: 4 front stages, the first loaded on the accepting edge, one
//   queue slot, 67 back stages.
// Stall: a stalled result freezes the back end; the front keeps accepting
//   until the 4-entry queue fills, then raises req_stall.
// Reset: clears all valid bits and the queue, and sets min_y_overlap
//   to 0.05 (3277).
// ----------------------------------------------------------------------------
module cylinder_box_push_out import cbp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [30:0] csr_data
);

   logic [30:0]   min_y_ff;
   logic          f_valid, q_full, q_valid, q_pop;
   back_item_type f_item, q_item;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_y_ff <= MIN_Y_RESET;
      end else if (csr_valid && csr_ready) begin
         min_y_ff <= csr_data;
      end
   end

   cbp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .min_y_overlap (min_y_ff),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .item_valid    (f_valid),
      .item_full     (q_full),
      .item_data     (f_item)
   );

   cbp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .full       (q_full),
      .push_data  (f_item),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_data   (q_item)
   );

   cbp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (q_valid),
      .item_pop   (q_pop),
      .item_data  (q_item),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule
